// ----- rtl/core/rrca_pkg.sv -----
// Shared constants and control types for the reorder receiver.
package rrca_pkg;

   localparam int SEQ_BITS     = 4;
   localparam int PAYLOAD_BITS = 64;
   localparam int CSR_BITS     = 4;
   localparam int SEQ_SPACE    = 1 << SEQ_BITS;
   localparam int WIN_CAP      = 8;
   localparam int WIN_LIM      = (SEQ_SPACE / 2 < WIN_CAP) ? SEQ_SPACE / 2 : WIN_CAP;
   localparam int WIN_W        = $clog2(WIN_LIM + 1);
   localparam int CMP_W        = (SEQ_BITS > WIN_W) ? SEQ_BITS : WIN_W;
   localparam int WIN_RESET    = 4;

   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   typedef logic [SEQ_BITS-1:0]     seq_type;
   typedef logic [PAYLOAD_BITS-1:0] payload_type;
   typedef logic [WIN_W-1:0]        win_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic scan_step;
      logic scan_done;
      logic load_deliver;
      logic load_ack;
   } dp_cmd_type;

   typedef struct packed {
      logic ok;
      logic in_win;
      logic at_base;
      logic prev_win;
      logic scan_hit;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/core/rrca_datapath.sv -----
// Datapath: window state, reorder buffer memory, scan counter and output register.
module rrca_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  rrca_pkg::seq_type            req_seq_num,
   input  logic                         req_checksum_ok,
   input  rrca_pkg::payload_type        req_payload,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [rrca_pkg::CSR_BITS-1:0] csr_window_size,
   input  rrca_pkg::dp_cmd_type         cmd,
   output rrca_pkg::dp_status_type      status,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic                         rsp_kind,
   output rrca_pkg::payload_type        rsp_deliver_data,
   output rrca_pkg::seq_type            rsp_ack_num,
   output logic                         rsp_last
);

   rrca_pkg::seq_type                   seq_ff, base_ff, base_in, ack_ff, ack_in;
   logic                                ok_ff;
   rrca_pkg::payload_type               data_ff, rd_data_ff;
   logic [rrca_pkg::CSR_BITS-1:0]       win_ff;
   logic [rrca_pkg::SEQ_SPACE-1:0]      valid_ff, valid_in;
   rrca_pkg::win_type                   idx_ff, idx_in, win_eff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_kind_ff, rsp_kind_in;
   rrca_pkg::payload_type               rsp_data_ff, rsp_data_in;
   rrca_pkg::seq_type                   rsp_ack_ff, rsp_ack_in;
   logic                                rsp_last_ff, rsp_last_in;
   rrca_pkg::payload_type               slot_mem [rrca_pkg::SEQ_SPACE];
   rrca_pkg::seq_type                   off, prev_start, prev_off, scan_slot, one;
   logic                                in_win, prev_win, store_en;

   assign one = rrca_pkg::SEQ_BITS'(1);

   // A zero window acts as one; larger values saturate at half the sequence space.
   always_comb begin
      if (win_ff == '0) begin
         win_eff = rrca_pkg::WIN_W'(1);
      end else if (win_ff > rrca_pkg::CSR_BITS'(rrca_pkg::WIN_LIM)) begin
         win_eff = rrca_pkg::WIN_W'(rrca_pkg::WIN_LIM);
      end else begin
         win_eff = rrca_pkg::WIN_W'(win_ff);
      end
   end

   assign off        = seq_ff - base_ff;
   assign in_win     = rrca_pkg::CMP_W'(off) < rrca_pkg::CMP_W'(win_eff);
   assign prev_start = base_ff - rrca_pkg::SEQ_BITS'(win_eff);
   assign prev_off   = seq_ff - prev_start;
   assign prev_win   = rrca_pkg::CMP_W'(prev_off) < rrca_pkg::CMP_W'(win_eff);
   assign scan_slot  = base_ff + rrca_pkg::SEQ_BITS'(idx_ff);
   assign store_en   = cmd.eval && ok_ff && in_win;

   assign status.ok       = ok_ff;
   assign status.in_win   = in_win;
   assign status.at_base  = (seq_ff == base_ff);
   assign status.prev_win = prev_win;
   assign status.scan_hit = (idx_ff < win_eff) && valid_ff[scan_slot];
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      base_in  = base_ff;
      ack_in   = ack_ff;
      if (store_en) begin
         valid_in[seq_ff] = 1'b1;
      end
      if (cmd.scan_step) begin
         valid_in[scan_slot] = 1'b0;
         idx_in              = idx_ff + rrca_pkg::WIN_W'(1);
      end
      if (cmd.eval) begin
         idx_in = '0;
         ack_in = in_win ? (base_ff - one) : seq_ff;
      end
      if (cmd.scan_done) begin
         base_in = scan_slot;
         ack_in  = scan_slot - one;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_ack_in   = rsp_ack_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load_deliver) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = rrca_pkg::KIND_DELIVER;
         rsp_data_in  = rd_data_ff;
         rsp_ack_in   = '0;
         rsp_last_in  = 1'b0;
      end else if (cmd.load_ack) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = rrca_pkg::KIND_ACK;
         rsp_data_in  = '0;
         rsp_ack_in   = ack_ff;
         rsp_last_in  = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= rrca_pkg::CSR_BITS'(rrca_pkg::WIN_RESET);
         base_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            win_ff <= csr_window_size;
         end
         base_ff      <= base_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seq_ff  <= req_seq_num;
         ok_ff   <= req_checksum_ok;
         data_ff <= req_payload;
      end
      idx_ff      <= idx_in;
      ack_ff      <= ack_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ack_ff  <= rsp_ack_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Reorder buffer: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (store_en) begin
         slot_mem[seq_ff] <= data_ff;
      end
      if (cmd.scan_step) begin
         rd_data_ff <= slot_mem[scan_slot];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_deliver_data = rsp_data_ff;
   assign rsp_ack_num      = rsp_ack_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ----- rtl/core/rrca_ctrl.sv -----
// Controller state machine that sequences classify, in-order release and ack.
module rrca_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rrca_pkg::dp_status_type status,
   output rrca_pkg::dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_EVAL    = 5'b00010,
      ST_SCAN    = 5'b00100,
      ST_DELIVER = 5'b01000,
      ST_ACK     = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (!status.ok) begin
               state_in = ST_IDLE;
            end else if (status.in_win && status.at_base) begin
               state_in = ST_SCAN;
            end else if (status.in_win || status.prev_win) begin
               state_in = ST_ACK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.scan_hit) begin
               cmd.scan_step = 1'b1;
               state_in      = ST_DELIVER;
            end else begin
               cmd.scan_done = 1'b1;
               state_in      = ST_ACK;
            end
         end
         ST_DELIVER: begin
            if (status.out_free) begin
               cmd.load_deliver = 1'b1;
               state_in         = ST_SCAN;
            end
         end
         ST_ACK: begin
            if (status.out_free) begin
               cmd.load_ack = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/reorder_receiver_cumulative_ack.sv -----
// A request is classified in the cycle after acceptance; an ack is loaded in the ACK state once
// the output register is free. Each packet released in order takes a buffer read, then an
// output load that waits for a free output register; the release scan ends in the final ack.
// Dropped or ignored requests end at classification; one request is in work at a time.
// Results leave through an output register, so a new request is taken while one waits.
// Synchronous reset clears window base, slot valid bits and output valid; window size is 4.
module reorder_receiver_cumulative_ack (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rrca_pkg::seq_type             req_seq_num,
   input  logic                          req_checksum_ok,
   input  rrca_pkg::payload_type         req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_kind,
   output rrca_pkg::payload_type         rsp_deliver_data,
   output rrca_pkg::seq_type             rsp_ack_num,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rrca_pkg::CSR_BITS-1:0] csr_window_size
);

   rrca_pkg::dp_cmd_type    cmd;
   rrca_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   rrca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rrca_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_seq_num      (req_seq_num),
      .req_checksum_ok  (req_checksum_ok),
      .req_payload      (req_payload),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_window_size  (csr_window_size),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_deliver_data (rsp_deliver_data),
      .rsp_ack_num      (rsp_ack_num),
      .rsp_last         (rsp_last)
   );

endmodule

// ----- rtl/core/rrca_checker.sv -----
// Port-level assertions for the reorder receiver, bound to the top level.
module rrca_assertions (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_kind,
   input rrca_pkg::payload_type rsp_deliver_data,
   input rrca_pkg::seq_type     rsp_ack_num,
   input logic                  rsp_last
);

   // A stalled result must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_ack_num))
      else $error("stalled result changed");

   // Every request that produces results ends in one ack, so only acks close a request.
   a_last_is_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == rsp_kind)
      else $error("last flag does not match result kind");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == rrca_pkg::KIND_ACK && rsp_deliver_data == '0) ||
                    (rsp_kind == rrca_pkg::KIND_DELIVER && rsp_ack_num == '0))
      else $error("unused result field is not zero");

   // The block works on one request at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind reorder_receiver_cumulative_ack rrca_assertions u_rrca_checker (.*);

// ----- tb/rrca_checker.sv -----
// Request, result and CSR monitor with a behavioral prediction of the reorder receiver.
module rrca_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  rrca_pkg::seq_type             req_seq_num,
   input  logic                          req_checksum_ok,
   input  rrca_pkg::payload_type         req_payload,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_kind,
   input  rrca_pkg::payload_type         rsp_deliver_data,
   input  rrca_pkg::seq_type             rsp_ack_num,
   input  logic                          rsp_last,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [rrca_pkg::CSR_BITS-1:0] csr_window_size,
   output int unsigned                   mismatch_count,
   output int unsigned                   owed_count,
   output int unsigned                   request_count,
   output int unsigned                   result_count,
   output int unsigned                   delivery_count,
   output int unsigned                   longest_burst
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic                  kind;
      rrca_pkg::payload_type data;
      rrca_pkg::seq_type     ack;
      logic                  last;
   } outcome_type;

   outcome_type                   owed_outputs [$];
   rrca_pkg::seq_type             base;
   logic [rrca_pkg::SEQ_SPACE-1:0] held;
   rrca_pkg::payload_type         held_data [rrca_pkg::SEQ_SPACE];
   logic [rrca_pkg::CSR_BITS-1:0] window_reg;
   int unsigned                   errors;
   int unsigned                   requests;
   int unsigned                   results;
   int unsigned                   deliveries;
   int unsigned                   burst_max;

   function automatic int unsigned window_span(input logic [rrca_pkg::CSR_BITS-1:0] w);
      if (w == '0) return 1;
      if (w > rrca_pkg::WIN_LIM) return rrca_pkg::WIN_LIM;
      return w;
   endfunction

   task automatic owe(input logic kind, input rrca_pkg::payload_type data,
                      input rrca_pkg::seq_type ack);
      owed_outputs.push_back('{kind: kind, data: data, ack: ack, last: 1'b0});
   endtask

   task automatic receive_packet(input rrca_pkg::seq_type s, input logic ok,
                                 input rrca_pkg::payload_type p);
      int unsigned       n;
      int unsigned       k;
      int unsigned       made;
      rrca_pkg::seq_type slot;
      n = window_span(window_reg);
      made = 0;
      if (!ok) return;
      if (rrca_pkg::seq_type'(s - base) < n) begin
         held[s] = 1'b1;
         held_data[s] = p;
         if (s == base) begin
            // Release the run of buffered packets starting at the base.
            for (k = 0; k < n; k++) begin
               slot = rrca_pkg::seq_type'(base + k);
               if (!held[slot]) break;
               owe(rrca_pkg::KIND_DELIVER, held_data[slot], '0);
               held[slot] = 1'b0;
               made++;
            end
            base = rrca_pkg::seq_type'(base + k);
         end
         owe(rrca_pkg::KIND_ACK, '0, rrca_pkg::seq_type'(base - 1));
         made++;
      end else if (rrca_pkg::seq_type'(s - rrca_pkg::seq_type'(base - n)) < n) begin
         // A retransmission from the window just passed is acked with its own number.
         owe(rrca_pkg::KIND_ACK, '0, s);
         made++;
      end
      if (made != 0) owed_outputs[owed_outputs.size() - 1].last = 1'b1;
      if (made > burst_max) burst_max = made;
   endtask

   task automatic check_result(input outcome_type got);
      outcome_type want;
      results++;
      if (got.kind == rrca_pkg::KIND_DELIVER) deliveries++;
      if (owed_outputs.size() == 0) begin
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("mismatch at %0t: unexpected result kind=%0b data=%h ack=%0d last=%0b",
                     $realtime, got.kind, got.data, got.ack, got.last);
         end
         return;
      end
      want = owed_outputs.pop_front();
      if (got.kind !== want.kind || got.data !== want.data ||
          got.ack !== want.ack || got.last !== want.last) begin
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("mismatch at %0t: expected kind=%0b data=%h ack=%0d last=%0b",
                     $realtime, want.kind, want.data, want.ack, want.last);
            $display("                  actual kind=%0b data=%h ack=%0d last=%0b",
                     got.kind, got.data, got.ack, got.last);
         end
      end
   endtask

   // A result is checked before a request of the same edge is predicted, since no
   // request can produce a result at the edge where it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         owed_outputs.delete();
         base = '0;
         held = '0;
         window_reg = rrca_pkg::CSR_BITS'(rrca_pkg::WIN_RESET);
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result('{kind: rsp_kind, data: rsp_deliver_data, ack: rsp_ack_num,
                           last: rsp_last});
         end
         if (csr_valid && csr_ready) window_reg = csr_window_size;
         if (req_valid && req_ready) begin
            requests++;
            receive_packet(req_seq_num, req_checksum_ok, req_payload);
         end
      end
      mismatch_count <= errors;
      owed_count     <= owed_outputs.size();
      request_count  <= requests;
      result_count   <= results;
      delivery_count <= deliveries;
      longest_burst  <= burst_max;
   end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the reorder receiver: clock, reset, stimulus, CSR writes and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IDLE_PCT     = 26;
   localparam int unsigned LONG_HOLD    = 300;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned PHASE_QUOTA  = 55;
   localparam int unsigned END_WAIT     = 20000;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned PHASES       = 7;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   rrca_pkg::seq_type             req_seq_num;
   logic                          req_checksum_ok;
   rrca_pkg::payload_type         req_payload;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic                          rsp_kind;
   rrca_pkg::payload_type         rsp_deliver_data;
   rrca_pkg::seq_type             rsp_ack_num;
   logic                          rsp_last;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [rrca_pkg::CSR_BITS-1:0] csr_window_size;

   int unsigned         mismatch_count;
   int unsigned         owed_count;
   int unsigned         request_count;
   int unsigned         result_count;
   int unsigned         delivery_count;
   int unsigned         longest_burst;
   int unsigned         cycle_count = 0;

   logic                          long_hold;
   logic                          steady_flow;
   logic [rrca_pkg::CSR_BITS-1:0] window_now;
   rrca_pkg::seq_type             stim_base;

   reorder_receiver_cumulative_ack i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_seq_num      (req_seq_num),
      .req_checksum_ok  (req_checksum_ok),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_deliver_data (rsp_deliver_data),
      .rsp_ack_num      (rsp_ack_num),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_window_size  (csr_window_size)
   );

   rrca_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_seq_num      (req_seq_num),
      .req_checksum_ok  (req_checksum_ok),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_deliver_data (rsp_deliver_data),
      .rsp_ack_num      (rsp_ack_num),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_window_size  (csr_window_size),
      .mismatch_count   (mismatch_count),
      .owed_count       (owed_count),
      .request_count    (request_count),
      .result_count     (result_count),
      .delivery_count   (delivery_count),
      .longest_burst    (longest_burst)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, owed_count);
         $display("FAIL");
         $finish;
      end
   end

   // Result side: random back-pressure, plus one long hold that fills the block.
   initial begin : rsp_side
      bit hold_served;
      hold_served = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold && !hold_served) begin
            hold_served = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function automatic rrca_pkg::payload_type rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic int unsigned span_of(input logic [rrca_pkg::CSR_BITS-1:0] w);
      if (w == '0) return 1;
      if (w > rrca_pkg::WIN_LIM) return rrca_pkg::WIN_LIM;
      return w;
   endfunction

   task automatic offer(input rrca_pkg::seq_type s, input logic ok,
                        input rrca_pkg::payload_type p);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_seq_num     <= s;
      req_checksum_ok <= ok;
      req_payload     <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_window(input logic [rrca_pkg::CSR_BITS-1:0] w);
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_count != 0);
      // Dropped or ignored requests may still be in work with nothing owed.
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_window_size <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_now = w;
   endtask

   // Sends whole windows in shuffled order so the base keeps moving, with noise mixed in:
   // bad checksums, repeats of packets already sent in the window, and far-off numbers.
   // The first window of a phase arrives in descending order to release a full burst.
   task automatic run_windows(input int unsigned quota);
      int unsigned       n;
      int unsigned       counted;
      int unsigned       k;
      int unsigned       j;
      int unsigned       far_room;
      rrca_pkg::seq_type order [rrca_pkg::WIN_LIM];
      rrca_pkg::seq_type tmp;
      bit                first;
      n = span_of(window_now);
      far_room = (3 * n < rrca_pkg::SEQ_SPACE) ? rrca_pkg::SEQ_SPACE - 3 * n : 0;
      counted = 0;
      first = 1'b1;
      while (counted < quota) begin
         for (k = 0; k < n; k++) begin
            order[k] = first ? rrca_pkg::seq_type'(stim_base + n - 1 - k)
                             : rrca_pkg::seq_type'(stim_base + k);
         end
         if (!first) begin
            for (k = n - 1; k > 0; k--) begin
               j = $urandom_range(k);
               tmp = order[k];
               order[k] = order[j];
               order[j] = tmp;
            end
         end
         first = 1'b0;
         for (k = 0; k < n; k++) begin
            offer(order[k], 1'b1, rand_word());
            counted++;
            if ($urandom_range(99) < 30) begin
               j = $urandom_range(99);
               if (j < 40) begin
                  offer(rrca_pkg::seq_type'($urandom), 1'b0, rand_word());
                  counted++;
               end else if (j < 75 || far_room == 0) begin
                  offer(order[$urandom_range(k)], 1'b1, rand_word());
                  counted++;
               end else begin
                  // Outside both the current and the previous window, whatever the base.
                  offer(rrca_pkg::seq_type'(stim_base + 2 * n + $urandom_range(far_room - 1)),
                        1'b1, rand_word());
                  counted++;
               end
            end
         end
         stim_base = rrca_pkg::seq_type'(stim_base + n);
      end
   endtask

   initial begin : stimulus
      int unsigned                   p;
      int unsigned                   k;
      logic [rrca_pkg::CSR_BITS-1:0] plan [PHASES];
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_seq_num     = '0;
      req_checksum_ok = 1'b0;
      req_payload     = '0;
      csr_valid       = 1'b0;
      csr_window_size = '0;
      long_hold       = 1'b0;
      steady_flow     = 1'b0;
      window_now      = rrca_pkg::CSR_BITS'(rrca_pkg::WIN_RESET);
      stim_base       = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests at the reset window of four, base starting at zero.
      offer(4'd0, 1'b0, '1);
      offer(4'd2, 1'b1, '0);
      offer(4'd2, 1'b1, '1);
      offer(4'd1, 1'b1, 64'hA5A5_5A5A_0F0F_F0F0);
      offer(4'd0, 1'b1, 64'h8000_0000_0000_0001);
      offer(4'd1, 1'b1, 64'h1234_5678_9ABC_DEF0);
      offer(4'd9, 1'b1, 64'h0000_0000_FFFF_FFFF);
      offer(4'd3, 1'b1, 64'hFFFF_FFFF_0000_0000);
      offer(4'd7, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE);
      offer(4'd6, 1'b1, 64'h5555_5555_5555_5555);
      offer(4'd5, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
      offer(4'd4, 1'b1, 64'h0000_0000_0000_0001);
      stim_base = 4'd8;

      plan = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd3, 4'd6, 4'd0};
      plan[PHASES - 1] = rrca_pkg::CSR_BITS'($urandom_range(15));
      for (p = 0; p < PHASES; p++) begin
         write_window(plan[p]);
         long_hold   <= (plan[p] == 4'd8);
         steady_flow <= (p == 4);
         run_windows(PHASE_QUOTA);
      end

      req_valid <= 1'b0;
      k = 0;
      do begin
         @(posedge clock);
         k++;
      end while (owed_count != 0 && k < END_WAIT);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests over %0d window settings, checking %0d results",
               request_count, PHASES + 1, result_count);
      $display("(%0d in-order deliveries, %0d acks, up to %0d results from one request).",
               delivery_count, result_count - delivery_count, longest_burst);
      if (owed_count != 0) $display("%0d expected results never arrived", owed_count);
      if (mismatch_count == 0 && owed_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
